// File: rtl/rvid_pkg.sv
// Shared opcodes, operation numbers, format codes and decode types for the RV32I decoder.
package rvid_pkg;

   // Major opcodes, bits 6:0 of the instruction word
   localparam logic [6:0] OPC_OP      = 7'b0110011;
   localparam logic [6:0] OPC_OPIMM   = 7'b0010011;
   localparam logic [6:0] OPC_JALR    = 7'b1100111;
   localparam logic [6:0] OPC_MISCMEM = 7'b0001111;
   localparam logic [6:0] OPC_SYSTEM  = 7'b1110011;
   localparam logic [6:0] OPC_STORE   = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
   localparam logic [6:0] OPC_LUI     = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
   localparam logic [6:0] OPC_JAL     = 7'b1101111;

   // funct7 values
   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   // funct3 values that need special handling
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_FENCE  = 3'd0;
   localparam logic [2:0] F3_FENCEI = 3'd1;
   localparam logic [2:0] F3_JALR = 3'd0;
   localparam logic [2:0] F3_SW   = 3'd2;

   // Fully fixed system words
   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   // Format codes
   localparam logic [2:0] FMT_R = 3'd0;
   localparam logic [2:0] FMT_I = 3'd1;
   localparam logic [2:0] FMT_S = 3'd2;
   localparam logic [2:0] FMT_B = 3'd3;
   localparam logic [2:0] FMT_U = 3'd4;
   localparam logic [2:0] FMT_J = 3'd5;

   // Dense operation numbers
   localparam logic [5:0] OP_ADD    = 6'd0;
   localparam logic [5:0] OP_SUB    = 6'd1;
   localparam logic [5:0] OP_SLL    = 6'd2;
   localparam logic [5:0] OP_SLT    = 6'd3;
   localparam logic [5:0] OP_SLTU   = 6'd4;
   localparam logic [5:0] OP_XOR    = 6'd5;
   localparam logic [5:0] OP_SRL    = 6'd6;
   localparam logic [5:0] OP_SRA    = 6'd7;
   localparam logic [5:0] OP_OR     = 6'd8;
   localparam logic [5:0] OP_AND    = 6'd9;
   localparam logic [5:0] OP_ADDI   = 6'd10;
   localparam logic [5:0] OP_SLTI   = 6'd11;
   localparam logic [5:0] OP_SLTIU  = 6'd12;
   localparam logic [5:0] OP_XORI   = 6'd13;
   localparam logic [5:0] OP_ORI    = 6'd14;
   localparam logic [5:0] OP_ANDI   = 6'd15;
   localparam logic [5:0] OP_SLLI   = 6'd16;
   localparam logic [5:0] OP_SRLI   = 6'd17;
   localparam logic [5:0] OP_SRAI   = 6'd18;
   localparam logic [5:0] OP_JALR   = 6'd19;
   localparam logic [5:0] OP_FENCE  = 6'd20;
   localparam logic [5:0] OP_FENCEI = 6'd21;
   localparam logic [5:0] OP_ECALL  = 6'd22;
   localparam logic [5:0] OP_EBREAK = 6'd23;
   localparam logic [5:0] OP_SB     = 6'd24;
   localparam logic [5:0] OP_SH     = 6'd25;
   localparam logic [5:0] OP_SW     = 6'd26;
   localparam logic [5:0] OP_BEQ    = 6'd27;
   localparam logic [5:0] OP_BNE    = 6'd28;
   localparam logic [5:0] OP_BLT    = 6'd29;
   localparam logic [5:0] OP_BGE    = 6'd30;
   localparam logic [5:0] OP_BLTU   = 6'd31;
   localparam logic [5:0] OP_BGEU   = 6'd32;
   localparam logic [5:0] OP_LUI    = 6'd33;
   localparam logic [5:0] OP_AUIPC  = 6'd34;
   localparam logic [5:0] OP_JAL    = 6'd35;

   // Decoded part of one word, passed from the decode logic to the result register
   typedef struct packed {
      logic        illegal;
      logic [2:0]  format_kind;
      logic [5:0]  op_id;
      logic [31:0] immediate;
   } dec_type;

   // R-type with base funct7, indexed by funct3
   function automatic logic [5:0] r_base_op(input logic [2:0] f3);
      logic [5:0] op;
      case (f3)
         3'd0:    op = OP_ADD;
         3'd1:    op = OP_SLL;
         3'd2:    op = OP_SLT;
         3'd3:    op = OP_SLTU;
         3'd4:    op = OP_XOR;
         3'd5:    op = OP_SRL;
         3'd6:    op = OP_OR;
         default: op = OP_AND;
      endcase
      return op;
   endfunction

   // OP-IMM, indexed by funct3 (shift rows are refined by funct7 elsewhere)
   function automatic logic [5:0] imm_op(input logic [2:0] f3);
      logic [5:0] op;
      case (f3)
         3'd0:    op = OP_ADDI;
         3'd1:    op = OP_SLLI;
         3'd2:    op = OP_SLTI;
         3'd3:    op = OP_SLTIU;
         3'd4:    op = OP_XORI;
         3'd5:    op = OP_SRLI;
         3'd6:    op = OP_ORI;
         default: op = OP_ANDI;
      endcase
      return op;
   endfunction

   // Branches, indexed by funct3; codes 2 and 3 are not branches
   function automatic logic [5:0] branch_op(input logic [2:0] f3);
      logic [5:0] op;
      case (f3)
         3'd0:    op = OP_BEQ;
         3'd1:    op = OP_BNE;
         3'd4:    op = OP_BLT;
         3'd5:    op = OP_BGE;
         3'd6:    op = OP_BLTU;
         default: op = OP_BGEU;
      endcase
      return op;
   endfunction

endpackage

// File: rtl/rvid_decode.sv
// Combinational decode of one RV32I word: format, operation number, illegal flag, immediate.
module rvid_decode (
   input  logic [31:0]     instr_word,
   output rvid_pkg::dec_type dec_out
);
   import rvid_pkg::*;

   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [2:0]  fmt;
   logic [5:0]  op;
   logic        hit;
   logic        known;
   logic        is_shamt;
   logic [31:0] imm;

   assign opc = instr_word[6:0];
   assign f3  = instr_word[14:12];
   assign f7  = instr_word[31:25];

   always_comb begin
      fmt      = FMT_R;
      op       = OP_ADD;
      hit      = 1'b0;
      known    = 1'b1;
      is_shamt = 1'b0;
      case (opc)
         OPC_OP: begin
            fmt = FMT_R;
            if (f7 == F7_BASE) begin
               op  = r_base_op(f3);
               hit = 1'b1;
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               op  = OP_SUB;
               hit = 1'b1;
            end else if (f7 == F7_ALT && f3 == F3_SR) begin
               op  = OP_SRA;
               hit = 1'b1;
            end
         end
         OPC_OPIMM: begin
            fmt = FMT_I;
            if (f3 == F3_SLL) begin
               op       = OP_SLLI;
               hit      = (f7 == F7_BASE);
               is_shamt = hit;
            end else if (f3 == F3_SR) begin
               op       = (f7 == F7_ALT) ? OP_SRAI : OP_SRLI;
               hit      = (f7 == F7_BASE) || (f7 == F7_ALT);
               is_shamt = hit;
            end else begin
               op  = imm_op(f3);
               hit = 1'b1;
            end
         end
         OPC_JALR: begin
            fmt = FMT_I;
            op  = OP_JALR;
            hit = (f3 == F3_JALR);
         end
         OPC_MISCMEM: begin
            fmt = FMT_I;
            op  = (f3 == F3_FENCEI) ? OP_FENCEI : OP_FENCE;
            hit = (f3 == F3_FENCE) || (f3 == F3_FENCEI);
         end
         OPC_SYSTEM: begin
            fmt = FMT_I;
            op  = (instr_word == WORD_EBREAK) ? OP_EBREAK : OP_ECALL;
            hit = (instr_word == WORD_ECALL) || (instr_word == WORD_EBREAK);
         end
         OPC_STORE: begin
            fmt = FMT_S;
            op  = OP_SB + {3'b000, f3};
            hit = (f3 <= F3_SW);
         end
         OPC_BRANCH: begin
            fmt = FMT_B;
            op  = branch_op(f3);
            hit = !(f3 inside {3'd2, 3'd3});
         end
         OPC_LUI: begin
            fmt = FMT_U;
            op  = OP_LUI;
            hit = 1'b1;
         end
         OPC_AUIPC: begin
            fmt = FMT_U;
            op  = OP_AUIPC;
            hit = 1'b1;
         end
         OPC_JAL: begin
            fmt = FMT_J;
            op  = OP_JAL;
            hit = 1'b1;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // Immediate: zero for unknown opcodes, shift amount for immediate shifts
   always_comb begin
      if (!known) begin
         imm = '0;
      end else if (is_shamt) begin
         imm = {27'b0, instr_word[24:20]};
      end else begin
         case (fmt)
            FMT_I:   imm = {{20{instr_word[31]}}, instr_word[31:20]};
            FMT_S:   imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
            FMT_B:   imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                            instr_word[30:25], instr_word[11:8], 1'b0};
            FMT_U:   imm = {instr_word[31:12], 12'b0};
            FMT_J:   imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                            instr_word[20], instr_word[30:21], 1'b0};
            default: imm = '0;
         endcase
      end
   end

   assign dec_out.illegal     = !hit;
   assign dec_out.format_kind = fmt;
   assign dec_out.op_id       = hit ? op : OP_ADD;
   assign dec_out.immediate   = imm;

endmodule

// File: rtl/rv32i_instruction_decoder.sv
// Top level of the RV32I decoder: input register, decode logic and result register.
//
// Decodes one RV32I instruction word per clock. Raise start with the word on
// req_instr_word; it is taken at any edge where busy is low, and busy is high
// only while reset is asserted, so a new word can enter in every cycle. Each
// word is registered in the input register, then passes through the decode logic
// into the result register; its result is driven on the rsp_ ports, marked by a
// one-cycle rsp_valid strobe, in the order taken. The receiver cannot stall:
// every strobed word must be captured in that cycle.
// rsp_illegal flags words that match none of the 36 recognized operations;
// loads are reported illegal. For an unknown opcode the format, operation
// number and immediate are zero; for a known opcode with a bad function field
// the operation number is zero while format and immediate follow the opcode.
// Register index outputs always carry their raw bit fields.
module rv32i_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_instr_word,
   output logic               rsp_valid,
   output logic               rsp_illegal,
   output logic [2:0]         rsp_format_kind,
   output logic [5:0]         rsp_op_id,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src_reg_a,
   output logic [4:0]         rsp_src_reg_b,
   output logic signed [31:0] rsp_immediate
);
   import rvid_pkg::*;

   logic        req_valid_ff, req_valid_in;
   logic [31:0] req_word_ff;
   logic        rsp_valid_ff;
   dec_type     rsp_dec_ff, rsp_dec_in;
   logic [4:0]  rsp_rd_ff, rsp_rs1_ff, rsp_rs2_ff;

   // Never hold off words outside reset
   assign busy = reset;

   // Capture a word on every accepted start
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // Payload registers: hold the word, then the decoded result
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_word_ff <= req_instr_word;
      end
      if (req_valid_ff) begin
         rsp_dec_ff <= rsp_dec_in;
         rsp_rd_ff  <= req_word_ff[11:7];
         rsp_rs1_ff <= req_word_ff[19:15];
         rsp_rs2_ff <= req_word_ff[24:20];
      end
   end

   // Decode the registered word
   rvid_decode u_decode (
      .instr_word (req_word_ff),
      .dec_out    (rsp_dec_in)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_illegal     = rsp_dec_ff.illegal;
   assign rsp_format_kind = rsp_dec_ff.format_kind;
   assign rsp_op_id       = rsp_dec_ff.op_id;
   assign rsp_dest_reg    = rsp_rd_ff;
   assign rsp_src_reg_a   = rsp_rs1_ff;
   assign rsp_src_reg_b   = rsp_rs2_ff;
   assign rsp_immediate   = signed'(rsp_dec_ff.immediate);

   // Every accepted word comes out as a result strobe
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted word did not produce a result");

   // No result without an earlier accepted word
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_valid_in, 2))
      else $error("result strobe without accepted word");

   // Illegal results report operation zero
   a_illegal_op : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_illegal) |-> (rsp_op_id == OP_ADD))
      else $error("illegal word with nonzero operation number");

   // Legal R-type results carry a zero immediate
   a_rtype_imm : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_illegal && rsp_format_kind == FMT_R) |-> (rsp_immediate == 32'sd0))
      else $error("R-type result with nonzero immediate");

   // The destination register field matches the accepted word
   a_reg_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dest_reg == $past(req_instr_word[11:7], 2)))
      else $error("destination field mismatch");

endmodule
